// ===== hdl/msi_capable_interrupt_controller_macros.svh =====
// Assertion macros for the interrupt controller.
`ifndef MSI_CAPABLE_INTERRUPT_CONTROLLER_MACROS_SVH
`define MSI_CAPABLE_INTERRUPT_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MCIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MCIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mcic_pkg.sv =====
package mcic_pkg;

  localparam int PIN_COUNT = 64;
  localparam int IDX_W = 6;
  localparam int DATA_W = 64;
  localparam int BYTE_W = 8;
  localparam logic [DATA_W-1:0] PIN_BITS =
    (PIN_COUNT >= DATA_W) ? {DATA_W{1'b1}} : ((DATA_W'(1) << PIN_COUNT) - DATA_W'(1));

  typedef enum logic [1:0] {
    MODE_LEVEL = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_MASK   = 3'd0,
    REG_STATUS = 3'd1,
    REG_EDGE   = 3'd2,
    REG_CLEAR  = 3'd3,
    REG_POL    = 3'd4,
    REG_MSI_EN = 3'd5,
    REG_VECTOR = 3'd6,
    REG_ROUTE  = 3'd7
  } reg_t;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_MSI    = 2'd1,
    KIND_LEGACY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_VEC,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] pin;
  } pick_t;

endpackage

// ===== hdl/msi_capable_interrupt_controller.sv =====
// Level-triggered interrupt controller with MSI vectors, 64 pins.
// Input channel (in_valid/in_ready): one transaction is a pin level change,
// a register write or a register read, selected by in_mode.
// Output channel (out_valid/out_ready): zero or more result transactions per
// input; out_last marks the final one. A read gives one read-data result.
// A change that raises or withdraws requests gives the combined legacy route
// event first (if any), then one MSI vector event per pin, ascending.
// Timing: an input is decoded the cycle after acceptance; a read result or a
// legacy event is loaded into the result register at the end of that cycle.
// Each MSI event passes through a vector table read, a result register load
// and the handshake, and waits while the receiver holds out_ready low.
// One item is in flight at a time; in_ready is high only when idle.
// Stall: the result register holds its transaction until out_ready; the walk
// over pending MSI pins waits with it.
// Reset (rst_n low, synchronous) clears the state and control registers and
// the per-entry valid bits of the vector and route tables, so both tables
// read as zero at once.
`include "msi_capable_interrupt_controller_macros.svh"

module msi_capable_interrupt_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_reg_req,
  input  logic [5:0]  in_index,
  input  logic [63:0] in_data,
  input  logic        in_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_vector,
  output logic        out_assert_level,
  output logic [63:0] out_read_data,
  output logic        out_last
);

  localparam int DW = mcic_pkg::DATA_W;
  localparam int IW = mcic_pkg::IDX_W;
  localparam int BW = mcic_pkg::BYTE_W;

  mcic_pkg::state_t state_r, state_nxt;

  // architectural registers
  logic [DW-1:0] raw_r, raw_nxt;
  logic [DW-1:0] isr_r, isr_nxt;
  logic [DW-1:0] mask_r, mask_nxt;
  logic [DW-1:0] edge_r, edge_nxt;
  logic [DW-1:0] pol_r, pol_nxt;
  logic [DW-1:0] msi_r, msi_nxt;
  logic [mcic_pkg::PIN_COUNT-1:0] vec_vld_r, vec_vld_nxt;
  logic [mcic_pkg::PIN_COUNT-1:0] rte_vld_r, rte_vld_nxt;
  logic vec_rv_r, rte_rv_r;

  // latched input transaction
  logic [1:0]    a_mode_r;
  logic [2:0]    a_req_r;
  logic [IW-1:0] a_index_r;
  logic [DW-1:0] a_data_r;
  logic          a_level_r;

  // event walk
  logic [DW-1:0] pend_r, pend_nxt;
  logic          lvl_r, lvl_nxt;

  // result register
  logic          ovalid_r, ovalid_nxt;
  logic [1:0]    okind_r, okind_nxt;
  logic [BW-1:0] ovec_r, ovec_nxt;
  logic          olvl_r, olvl_nxt;
  logic [DW-1:0] ord_r, ord_nxt;
  logic          olast_r, olast_nxt;

  // tables
  logic          vec_we, rte_we;
  logic [IW-1:0] vec_raddr;
  logic [BW-1:0] vec_q, rte_q, vec_val, rte_val;
  mcic_pkg::pick_t pick;

  mcic_ram #(.DEPTH(mcic_pkg::PIN_COUNT), .WIDTH(BW)) u_vec_ram (
    .clk  (clk),
    .we   (vec_we),
    .waddr(a_index_r),
    .wdata(a_data_r[BW-1:0]),
    .raddr(vec_raddr),
    .rdata(vec_q)
  );

  mcic_ram #(.DEPTH(mcic_pkg::PIN_COUNT), .WIDTH(BW)) u_rte_ram (
    .clk  (clk),
    .we   (rte_we),
    .waddr(a_index_r),
    .wdata(a_data_r[BW-1:0]),
    .raddr(in_index),
    .rdata(rte_q)
  );

  mcic_pick u_pick (
    .pend(pend_r),
    .pick(pick)
  );

  assign vec_val = vec_rv_r ? vec_q : '0;
  assign rte_val = rte_rv_r ? rte_q : '0;

  assign in_ready         = (state_r == mcic_pkg::ST_IDLE);
  assign out_valid        = ovalid_r;
  assign out_kind         = okind_r;
  assign out_vector       = ovec_r;
  assign out_assert_level = olvl_r;
  assign out_read_data    = ord_r;
  assign out_last         = olast_r;

  // vector table: read at the incoming index when idle, at the picked pin during the walk
  assign vec_raddr = (state_r == mcic_pkg::ST_FETCH) ? pick.pin : in_index;

  always_comb begin
    logic [DW-1:0] d, bsel, m, v, leg, mv, rd;
    logic          idx_ok, do_raise, do_lower, leg_ev, clr_after;

    state_nxt   = state_r;
    raw_nxt     = raw_r;
    isr_nxt     = isr_r;
    mask_nxt    = mask_r;
    edge_nxt    = edge_r;
    pol_nxt     = pol_r;
    msi_nxt     = msi_r;
    vec_vld_nxt = vec_vld_r;
    rte_vld_nxt = rte_vld_r;
    pend_nxt    = pend_r;
    lvl_nxt     = lvl_r;
    ovalid_nxt  = ovalid_r;
    okind_nxt   = okind_r;
    ovec_nxt    = ovec_r;
    olvl_nxt    = olvl_r;
    ord_nxt     = ord_r;
    olast_nxt   = olast_r;
    vec_we      = 1'b0;
    rte_we      = 1'b0;

    d         = a_data_r & mcic_pkg::PIN_BITS;
    bsel      = DW'(1) << a_index_r;
    idx_ok    = ({1'b0, a_index_r} < (IW + 1)'(mcic_pkg::PIN_COUNT));
    m         = '0;
    v         = '0;
    leg       = '0;
    mv        = '0;
    rd        = '0;
    do_raise  = 1'b0;
    do_lower  = 1'b0;
    leg_ev    = 1'b0;
    clr_after = 1'b0;

    case (state_r)
      mcic_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = mcic_pkg::ST_EXEC;
        end
      end

      mcic_pkg::ST_EXEC: begin
        state_nxt = mcic_pkg::ST_IDLE;
        case (a_mode_r)
          mcic_pkg::MODE_LEVEL: begin
            if (idx_ok && ((edge_r & bsel) == '0)) begin
              if (a_level_r && ((raw_r & bsel) == '0)) begin
                raw_nxt  = raw_r | bsel;
                m        = bsel;
                do_raise = 1'b1;
              end else if (!a_level_r && ((raw_r & bsel) != '0)) begin
                raw_nxt  = raw_r & ~bsel;
                m        = bsel;
                do_lower = 1'b1;
              end
            end
          end
          mcic_pkg::MODE_WRITE: begin
            case (a_req_r)
              mcic_pkg::REG_MASK: begin
                mask_nxt = d;
                if ((mask_r & ~d) != '0) begin
                  m        = mask_r & ~d;
                  do_raise = 1'b1;
                end else if ((~mask_r & d) != '0) begin
                  m        = ~mask_r & d;
                  do_lower = 1'b1;
                end
              end
              mcic_pkg::REG_STATUS: isr_nxt = d;
              mcic_pkg::REG_EDGE:   edge_nxt = d;
              mcic_pkg::REG_CLEAR: begin
                m         = d;
                do_lower  = 1'b1;
                clr_after = 1'b1;
              end
              mcic_pkg::REG_POL:    pol_nxt = d;
              mcic_pkg::REG_MSI_EN: msi_nxt = d;
              mcic_pkg::REG_VECTOR: begin
                if (idx_ok) begin
                  vec_we = 1'b1;
                  vec_vld_nxt[a_index_r] = 1'b1;
                end
              end
              default: begin
                if (idx_ok) begin
                  rte_we = 1'b1;
                  rte_vld_nxt[a_index_r] = 1'b1;
                end
              end
            endcase
          end
          mcic_pkg::MODE_READ: begin
            case (a_req_r)
              mcic_pkg::REG_MASK:   rd = mask_r;
              mcic_pkg::REG_STATUS: rd = isr_r & ~mask_r;
              mcic_pkg::REG_EDGE:   rd = edge_r;
              mcic_pkg::REG_CLEAR:  rd = '0;
              mcic_pkg::REG_POL:    rd = pol_r;
              mcic_pkg::REG_MSI_EN: rd = msi_r;
              mcic_pkg::REG_VECTOR: rd = idx_ok ? DW'(vec_val) : '0;
              default:              rd = idx_ok ? DW'(rte_val) : '0;
            endcase
            ovalid_nxt = 1'b1;
            okind_nxt  = mcic_pkg::KIND_READ;
            ovec_nxt   = '0;
            olvl_nxt   = 1'b0;
            ord_nxt    = rd;
            olast_nxt  = 1'b1;
            pend_nxt   = '0;
            state_nxt  = mcic_pkg::ST_WAIT;
          end
          default: ;
        endcase

        // raise: unmasked requesting pins; lower: pins in service
        if (do_raise) begin
          v        = m & raw_nxt & ~mask_nxt & mcic_pkg::PIN_BITS;
          leg      = v & ~msi_r;
          mv       = v & msi_r;
          leg_ev   = (leg != '0) && ((isr_r & leg) == '0);
          pend_nxt = mv & ~isr_r;
          // legacy pins enter service only with a fresh legacy raise
          isr_nxt  = isr_r | (leg_ev ? leg : '0) | mv;
          lvl_nxt  = 1'b1;
        end else if (do_lower) begin
          v        = m & isr_r;
          leg      = v & ~msi_r;
          leg_ev   = (leg != '0);
          pend_nxt = v & msi_r;
          isr_nxt  = clr_after ? (isr_r & ~v & ~d) : (isr_r & ~v);
          lvl_nxt  = 1'b0;
        end

        if (do_raise || do_lower) begin
          if (leg_ev) begin
            ovalid_nxt = 1'b1;
            okind_nxt  = mcic_pkg::KIND_LEGACY;
            ovec_nxt   = '0;
            olvl_nxt   = lvl_nxt;
            ord_nxt    = '0;
            olast_nxt  = (pend_nxt == '0);
            state_nxt  = mcic_pkg::ST_WAIT;
          end else if (pend_nxt != '0) begin
            state_nxt = mcic_pkg::ST_FETCH;
          end
        end
      end

      mcic_pkg::ST_FETCH: begin
        // read the lowest pending pin's vector, drop it from the walk
        pend_nxt  = pend_r & ~(DW'(1) << pick.pin);
        state_nxt = mcic_pkg::ST_VEC;
      end

      mcic_pkg::ST_VEC: begin
        ovalid_nxt = 1'b1;
        okind_nxt  = mcic_pkg::KIND_MSI;
        ovec_nxt   = vec_val;
        olvl_nxt   = lvl_r;
        ord_nxt    = '0;
        olast_nxt  = (pend_r == '0);
        state_nxt  = mcic_pkg::ST_WAIT;
      end

      mcic_pkg::ST_WAIT: begin
        if (out_ready) begin
          ovalid_nxt = 1'b0;
          state_nxt  = pick.found ? mcic_pkg::ST_FETCH : mcic_pkg::ST_IDLE;
        end
      end

      default: state_nxt = mcic_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mcic_pkg::ST_IDLE;
      raw_r     <= '0;
      isr_r     <= '0;
      mask_r    <= '0;
      edge_r    <= '0;
      pol_r     <= '0;
      msi_r     <= '0;
      vec_vld_r <= '0;
      rte_vld_r <= '0;
      vec_rv_r  <= 1'b0;
      rte_rv_r  <= 1'b0;
      pend_r    <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      raw_r     <= raw_nxt;
      isr_r     <= isr_nxt;
      mask_r    <= mask_nxt;
      edge_r    <= edge_nxt;
      pol_r     <= pol_nxt;
      msi_r     <= msi_nxt;
      vec_vld_r <= vec_vld_nxt;
      rte_vld_r <= rte_vld_nxt;
      vec_rv_r  <= vec_vld_r[vec_raddr];
      rte_rv_r  <= rte_vld_r[in_index];
      pend_r    <= pend_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_mode_r  <= in_mode;
      a_req_r   <= in_reg_req;
      a_index_r <= in_index;
      a_data_r  <= in_data;
      a_level_r <= in_level;
    end
    lvl_r   <= lvl_nxt;
    okind_r <= okind_nxt;
    ovec_r  <= ovec_nxt;
    olvl_r  <= olvl_nxt;
    ord_r   <= ord_nxt;
    olast_r <= olast_nxt;
  end

  `MCIC_ASSERT_NOW(a_idle_no_result, in_ready, !out_valid, "result pending while idle")
  `MCIC_ASSERT_NEXT(a_last_to_idle, out_valid && out_ready && out_last, in_ready, "no idle after last")
  `MCIC_ASSERT_NOW(a_read_is_last, out_valid && (out_kind == mcic_pkg::KIND_READ), out_last, "read not last")
  `MCIC_ASSERT_NOW(a_event_no_data, out_valid && (out_kind != mcic_pkg::KIND_READ), out_read_data == '0, "event carries data")

endmodule

// ===== hdl/mcic_ram.sv =====
module mcic_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mcic_pick.sv =====
module mcic_pick (
  input  logic [mcic_pkg::DATA_W-1:0] pend,
  output mcic_pkg::pick_t             pick
);

  logic [mcic_pkg::DATA_W-1:0] low_hot;

  // isolate the lowest pending pin, then encode it
  always_comb begin
    low_hot = pend & (~pend + mcic_pkg::DATA_W'(1));
    pick.found = |pend;
    pick.pin = '0;
    for (int i = 0; i < mcic_pkg::DATA_W; i++) begin
      if (low_hot[i]) begin
        pick.pin = pick.pin | mcic_pkg::IDX_W'(i);
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

// Interrupt controller state mirror and result queue.
class irq_scoreboard;
  logic [63:0] raw_req, in_svc, mask_r, edge_r, pol_r, msi_en;
  logic [7:0]  vec_tab [64];
  logic [7:0]  route_tab [64];
  logic [75:0] pending [$];   // {kind, vector, level, data, last}
  int          errors;

  function new();
    raw_req = '0; in_svc = '0; mask_r = '0; edge_r = '0; pol_r = '0; msi_en = '0;
    for (int i = 0; i < 64; i++) begin
      vec_tab[i] = '0;
      route_tab[i] = '0;
    end
    errors = 0;
  endfunction

  function void push_event(mcic_pkg::kind_t k, logic [7:0] v, logic l, logic [63:0] d);
    pending.push_back({k, v, l, d, 1'b0});
  endfunction

  function void raise_pins(logic [63:0] m);
    logic [63:0] v, leg, msi;
    v = m & raw_req & ~mask_r & mcic_pkg::PIN_BITS;
    leg = v & ~msi_en;
    msi = v & msi_en;
    if (leg != 0 && (in_svc & leg) == 0) begin
      in_svc |= leg;
      push_event(mcic_pkg::KIND_LEGACY, 8'd0, 1'b1, 64'd0);
    end
    for (int i = 0; i < 64; i++)
      if (msi[i] && !in_svc[i]) begin
        in_svc[i] = 1'b1;
        push_event(mcic_pkg::KIND_MSI, vec_tab[i], 1'b1, 64'd0);
      end
  endfunction

  function void lower_pins(logic [63:0] m);
    logic [63:0] v, leg, msi;
    v = m & in_svc;
    leg = v & ~msi_en;
    msi = v & msi_en;
    if (leg != 0) begin
      in_svc &= ~leg;
      push_event(mcic_pkg::KIND_LEGACY, 8'd0, 1'b0, 64'd0);
    end
    for (int i = 0; i < 64; i++)
      if (msi[i] && in_svc[i]) begin
        in_svc[i] = 1'b0;
        push_event(mcic_pkg::KIND_MSI, vec_tab[i], 1'b0, 64'd0);
      end
  endfunction

  // Note an accepted input transaction; predict its results.
  function void note_input(logic [1:0] mode, logic [2:0] rq, logic [5:0] idx,
                           logic [63:0] data, logic lvl);
    int          prior_count;
    logic [63:0] d, old, r;
    prior_count = pending.size();
    d = data & mcic_pkg::PIN_BITS;
    if (mode == mcic_pkg::MODE_LEVEL) begin
      if (!edge_r[idx]) begin
        if (lvl && !raw_req[idx]) begin
          raw_req[idx] = 1'b1;
          raise_pins(64'd1 << idx);
        end else if (!lvl && raw_req[idx]) begin
          raw_req[idx] = 1'b0;
          lower_pins(64'd1 << idx);
        end
      end
    end else if (mode == mcic_pkg::MODE_WRITE) begin
      case (rq)
        mcic_pkg::REG_MASK: begin
          old = mask_r;
          mask_r = d;
          if ((old & ~d) != 0) raise_pins(old & ~d);
          else if ((~old & d) != 0) lower_pins(~old & d);
        end
        mcic_pkg::REG_STATUS: in_svc = d;
        mcic_pkg::REG_EDGE:   edge_r = d;
        mcic_pkg::REG_CLEAR: begin
          lower_pins(d);
          in_svc &= ~d;
        end
        mcic_pkg::REG_POL:    pol_r = d;
        mcic_pkg::REG_MSI_EN: msi_en = d;
        mcic_pkg::REG_VECTOR: vec_tab[idx] = data[7:0];
        default:              route_tab[idx] = data[7:0];
      endcase
    end else if (mode == mcic_pkg::MODE_READ) begin
      case (rq)
        mcic_pkg::REG_MASK:   r = mask_r;
        mcic_pkg::REG_STATUS: r = in_svc & ~mask_r;
        mcic_pkg::REG_EDGE:   r = edge_r;
        mcic_pkg::REG_CLEAR:  r = 64'd0;
        mcic_pkg::REG_POL:    r = pol_r;
        mcic_pkg::REG_MSI_EN: r = msi_en;
        mcic_pkg::REG_VECTOR: r = {56'd0, vec_tab[idx]};
        default:              r = {56'd0, route_tab[idx]};
      endcase
      push_event(mcic_pkg::KIND_READ, 8'd0, 1'b0, r);
    end
    if (pending.size() > prior_count)
      pending[pending.size()-1][0] = 1'b1;
  endfunction

  // Compare one accepted result with the oldest expectation.
  function void check_result(logic [75:0] got, realtime t);
    logic [75:0] want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", t, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got[75:74] != want[75:74])
      $display("%0t: kind exp %0d act %0d", t, want[75:74], got[75:74]);
    if (got[73:66] != want[73:66])
      $display("%0t: vector exp %0d act %0d", t, want[73:66], got[73:66]);
    if (got[65] != want[65])
      $display("%0t: assert_level exp %0d act %0d", t, want[65], got[65]);
    if (got[64:1] != want[64:1])
      $display("%0t: read_data exp %h act %h", t, want[64:1], got[64:1]);
    if (got[0] != want[0])
      $display("%0t: last exp %0d act %0d", t, want[0], got[0]);
    if (got != want) errors++;
  endfunction
endclass

module testbench;
  // mode code the block ignores
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_level;
  logic [1:0]  in_mode;
  logic [2:0]  in_reg_req;
  logic [5:0]  in_index;
  logic [63:0] in_data;
  logic        out_valid, out_ready, out_assert_level, out_last;
  logic [1:0]  out_kind;
  logic [7:0]  out_vector;
  logic [63:0] out_read_data;

  irq_scoreboard sb;
  int            cycle_count = 0;

  msi_capable_interrupt_controller u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: generous bound on the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4000000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Send one transaction, waiting a random gap first; hold until accepted.
  task automatic send_item(logic [1:0] m, logic [2:0] rq, logic [5:0] idx,
                           logic [63:0] d, logic lvl);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= m;
    in_reg_req <= rq;
    in_index   <= idx;
    in_data    <= d;
    in_level   <= lvl;
    do @(posedge clk); while (!in_ready);
    sb.note_input(m, rq, idx, d, lvl);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random pattern biased toward sparse or dense sets of pins.
  function automatic logic [63:0] rand_pins();
    case ($urandom_range(0, 3))
      0: return rand64() & rand64() & rand64();
      1: return rand64() | rand64();
      2: return 64'd1 << $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  // Receiver: stall randomly, check each accepted result.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result({out_kind, out_vector, out_assert_level, out_read_data, out_last},
                      $realtime);
    end
  end

  initial begin
    sb = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_mode    = mcic_pkg::MODE_LEVEL;
    in_reg_req = mcic_pkg::REG_MASK;
    in_index   = '0;
    in_data    = '0;
    in_level   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: tables, MSI fan-out, legacy, mask both ways, edge pins, clear.
    send_item(mcic_pkg::MODE_WRITE, mcic_pkg::REG_VECTOR, 6'd0, 64'hff, 0);
    send_item(mcic_pkg::MODE_WRITE, mcic_pkg::REG_VECTOR, 6'd63, 64'hffff_ffff_ffff_ff5a, 0);
    send_item(mcic_pkg::MODE_WRITE, mcic_pkg::REG_ROUTE, 6'd63, 64'hff, 0);
    send_item(mcic_pkg::MODE_READ, mcic_pkg::REG_VECTOR, 6'd63, 0, 0);
    send_item(mcic_pkg::MODE_READ, mcic_pkg::REG_ROUTE, 6'd63, 0, 0);
    send_item(mcic_pkg::MODE_WRITE, mcic_pkg::REG_MSI_EN, 0, 64'h8000_0000_0000_0001, 0);
    send_item(mcic_pkg::MODE_WRITE, mcic_pkg::REG_MASK, 0, '1, 0);
    send_item(mcic_pkg::MODE_LEVEL, mcic_pkg::REG_MASK, 6'd0, 0, 1);
    send_item(mcic_pkg::MODE_LEVEL, mcic_pkg::REG_MASK, 6'd63, 0, 1);
    send_item(mcic_pkg::MODE_LEVEL, mcic_pkg::REG_MASK, 6'd5, 0, 1);
    send_item(mcic_pkg::MODE_WRITE, mcic_pkg::REG_MASK, 0, 0, 0);
    send_item(mcic_pkg::MODE_READ, mcic_pkg::REG_STATUS, 0, 0, 0);
    send_item(mcic_pkg::MODE_WRITE, mcic_pkg::REG_MASK, 0, '1, 0);
    send_item(mcic_pkg::MODE_WRITE, mcic_pkg::REG_MASK, 0, 0, 0);
    send_item(mcic_pkg::MODE_WRITE, mcic_pkg::REG_CLEAR, 0, '1, 0);
    send_item(mcic_pkg::MODE_READ, mcic_pkg::REG_CLEAR, 0, 0, 0);
    send_item(mcic_pkg::MODE_WRITE, mcic_pkg::REG_EDGE, 0, 64'h20, 0);
    send_item(mcic_pkg::MODE_LEVEL, mcic_pkg::REG_MASK, 6'd5, 0, 0);
    send_item(mcic_pkg::MODE_READ, mcic_pkg::REG_EDGE, 0, 0, 0);
    send_item(mcic_pkg::MODE_WRITE, mcic_pkg::REG_STATUS, 0, '1, 0);
    send_item(mcic_pkg::MODE_WRITE, mcic_pkg::REG_POL, 0, '1, 0);
    send_item(mcic_pkg::MODE_READ, mcic_pkg::REG_POL, 0, 0, 0);
    send_item(mcic_pkg::MODE_READ, mcic_pkg::REG_MSI_EN, 0, 0, 0);
    send_item(mcic_pkg::MODE_LEVEL, mcic_pkg::REG_MASK, 6'd0, 0, 0);
    send_item(MODE_UNUSED, mcic_pkg::REG_MASK, 0, '1, 1);

    // Random: mostly level changes, with register writes and reads on random pin sets.
    for (int n = 0; n < 325; n++) begin
      logic [1:0] m;
      logic [2:0] rq;
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 45)      m = mcic_pkg::MODE_LEVEL;
      else if (sel < 75) m = mcic_pkg::MODE_WRITE;
      else if (sel < 97) m = mcic_pkg::MODE_READ;
      else               m = MODE_UNUSED;
      rq = 3'($urandom_range(0, 7));
      if (m == mcic_pkg::MODE_WRITE && rq == mcic_pkg::REG_EDGE && $urandom_range(0, 1))
        rq = mcic_pkg::REG_MASK;
      send_item(m, rq, 6'($urandom_range(0, 63)),
                (m == mcic_pkg::MODE_WRITE && rq == mcic_pkg::REG_EDGE)
                  ? (rand64() & rand64() & rand64()) : rand_pins(),
                1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;

    // Drain: wait for outstanding results, then a tail for stray outputs.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
